### hw/rtl/fbf_pkg.sv
// Shared types and constants for the FENE bond force block.
// Holds the request/response payload structs and the divider handshake structs.
// No dependencies.
package fbf_pkg;

   localparam int DIV_NUM_W = 96;
   localparam int DIV_DEN_W = 64;
   localparam int DIV_CNT_W = 7;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_SPRING_K          = 3'd0;
   localparam logic [2:0] CSR_MAX_EXTENT        = 3'd1;
   localparam logic [2:0] CSR_USE_TYPE_TABLE    = 3'd2;
   localparam logic [2:0] CSR_BOX_LENGTH        = 3'd3;
   localparam logic [2:0] CSR_TYPE_ONE_K        = 3'd4;
   localparam logic [2:0] CSR_TYPE_ONE_EXTENT   = 3'd5;
   localparam logic [2:0] CSR_TYPE_TWO_K        = 3'd6;
   localparam logic [2:0] CSR_TYPE_TWO_EXTENT   = 3'd7;

   localparam logic [31:0] RESET_SPRING_K   = 32'h0001_0000;
   localparam logic [31:0] RESET_MAX_EXTENT = 32'h0001_8000;

   localparam logic [31:0] LN2_Q32       = 32'hB172_17F8;
   localparam logic [39:0] FORCE_MAX     = 40'h7F_FFFF_FFFF;
   localparam logic [39:0] FORCE_MIN_MAG = 40'h80_0000_0000;
   localparam logic [47:0] ENERGY_MAX    = 48'hFFFF_FFFF_FFFF;
   localparam logic [55:0] SUM_MAX       = 56'hFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic signed [31:0] first_x;
      logic signed [31:0] first_y;
      logic signed [31:0] first_z;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_z;
      logic [1:0]         bond_type;
      logic               first_of_pass;
   } fbf_req_type;

   typedef struct packed {
      logic signed [39:0] force_x;
      logic signed [39:0] force_y;
      logic signed [39:0] force_z;
      logic [47:0]        bond_energy;
      logic [55:0]        energy_total;
      logic               overstretched;
   } fbf_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_NUM_W-1:0]  numer;
      logic [DIV_DEN_W-1:0]  denom;
      logic [DIV_CNT_W-1:0]  iters;
   } fbf_div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIV_DEN_W-1:0]  quot;
      logic [DIV_DEN_W-1:0]  rem;
   } fbf_div_rsp_type;

endpackage

### hw/rtl/fbf_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
// Depends on nothing but the clock.
module fbf_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] mul_p
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= {32'b0, mul_a} * {32'b0, mul_b};
   end

   assign mul_p = prod_ff;

endmodule

### hw/rtl/fbf_div.sv
// Restoring divider, one quotient bit per cycle.
// The numerator is top aligned; only its upper iters bits are used.
// Depends on fbf_pkg.
module fbf_div import fbf_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  fbf_div_req_type div_req,
   output fbf_div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] quot_ff, quot_in;
   logic [DIV_DEN_W:0]   rem_shift;
   logic [DIV_DEN_W:0]   rem_diff;
   logic                 fits;

   assign rem_shift = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = div_req.iters;
         num_in  = div_req.numer;
         den_in  = div_req.denom;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_in  = fits ? rem_diff[DIV_DEN_W-1:0] : rem_shift[DIV_DEN_W-1:0];
         quot_in = {quot_ff[DIV_DEN_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

### hw/rtl/fene_bond_force.sv
// FENE bond force and energy unit, top level.
// Holds the configuration registers, the sequencer and the datapath registers.
// Depends on fbf_pkg, fbf_mul and fbf_div.
//
// Usage: one bond is presented per transaction on the req_ channel (two particle
// positions, a bond type and a first-of-pass mark). One result transaction per
// bond leaves on the rsp_ channel: the force on the first particle, the bond
// energy, the running energy of the pass and an overstretch flag.
// A transaction is taken at a clock edge where valid is high and stall is low.
// The block works on one bond at a time and holds req_stall high until that
// bond's result has been written to the output register. A result that waits
// on a stalled receiver does not block the next bond from being taken; only
// the following result waits for the output register to free up.
// The time per bond is set by the shared divider, which makes one quotient bit
// per cycle for the fraction, the force factor and, when box wrap is on
// (box_length not zero), each axis of the fold, and by the 32 squarings of the
// logarithm on the single shared multiplier. A bond that fails the length
// check skips the division and logarithm and goes to the finishing step; one
// whose fraction truncates to zero stops after the fraction division. Reset
// is synchronous: it loads the registers with their defaults, clears the pass
// energy and empties the output register. The user must see that configuration
// is written through csr_ only while the block is idle; it is not enforced.
module fene_bond_force import fbf_pkg::*; #(
   parameter int NUM_BOND_TYPES = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fbf_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fbf_rsp_type rsp_payload,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRAP_GO, ST_WRAP_WAIT, ST_SQUARE, ST_CHECK, ST_FACT_GO, ST_FACT_WAIT,
      ST_NORM, ST_LOG, ST_LN, ST_KNL, ST_QR, ST_G_GO, ST_G_WAIT, ST_FORCE, ST_FINISH
   } state_type;

   // Configuration registers.
   logic [31:0] spring_k_ff, max_extent_ff, box_length_ff;
   logic [31:0] type_one_k_ff, type_one_extent_ff, type_two_k_ff, type_two_extent_ff;
   logic        use_type_table_ff;

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   logic [5:0]         step_ff, step_in;
   logic [1:0]         axis_ff, axis_in;
   logic               fop_ff, fop_in;
   logic signed [32:0] d_ff [3];
   logic signed [32:0] d_in [3];
   logic [31:0]        k_ff, k_in, r0_ff, r0_in;
   logic [63:0]        r0sq_ff, r0sq_in;
   logic [103:0]       acc_ff, acc_in;
   logic               over_ff, over_in;
   logic [32:0]        f_ff, f_in, norm_ff, norm_in;
   logic [5:0]         shift_ff, shift_in;
   logic [31:0]        m_ff, m_in, lm_ff, lm_in;
   logic [37:0]        nl_ff, nl_in;
   logic [38:0]        q_ff, q_in;
   logic [63:0]        g_ff, g_in;
   logic               tsat_ff, tsat_in;
   logic [22:0]        tlow_ff, tlow_in;
   logic [48:0]        fmag_ff [3];
   logic [48:0]        fmag_in [3];
   logic [55:0]        sum_ff, sum_in;
   fbf_rsp_type        rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Shared units.
   logic [31:0]     mul_a, mul_b;
   logic [63:0]     mul_p;
   fbf_div_req_type div_req;
   fbf_div_rsp_type div_rsp;

   // Helper signals.
   logic signed [32:0] raw_d [3];
   logic [31:0]        wrap_rem;
   logic [32:0]        wrap_pos;
   logic [32:0]        wrap_fin;
   logic [37:0]        nl2;
   logic [32:0]        log_t;
   logic [47:0]        energy;
   logic [56:0]        sum_wide;
   logic [48:0]        force_mag [3];
   logic [103:0]       prod_wide;

   function automatic logic [31:0] mag32(input logic signed [32:0] v);
      logic [32:0] n;
      n = -v;
      return v[32] ? n[31:0] : v[31:0];
   endfunction

   function automatic logic signed [39:0] force_value(input logic signed [32:0] d,
                                                      input logic [48:0] mag);
      logic [39:0] lim;
      lim = '0;
      if (d == '0) begin
         return '0;
      end
      if (!d[32]) begin
         lim = (mag > {9'b0, FORCE_MAX}) ? FORCE_MAX : mag[39:0];
         return signed'(lim);
      end
      lim = (mag > {9'b0, FORCE_MIN_MAG}) ? FORCE_MIN_MAG : mag[39:0];
      return signed'(-lim);
   endfunction

   fbf_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   fbf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         spring_k_ff        <= RESET_SPRING_K;
         max_extent_ff      <= RESET_MAX_EXTENT;
         use_type_table_ff  <= 1'b0;
         box_length_ff      <= '0;
         type_one_k_ff      <= RESET_SPRING_K;
         type_one_extent_ff <= RESET_MAX_EXTENT;
         type_two_k_ff      <= RESET_SPRING_K;
         type_two_extent_ff <= RESET_MAX_EXTENT;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SPRING_K:        spring_k_ff        <= csr_data;
            CSR_MAX_EXTENT:      max_extent_ff      <= csr_data;
            CSR_USE_TYPE_TABLE:  use_type_table_ff  <= csr_data[0];
            CSR_BOX_LENGTH:      box_length_ff      <= csr_data;
            CSR_TYPE_ONE_K:      type_one_k_ff      <= csr_data;
            CSR_TYPE_ONE_EXTENT: type_one_extent_ff <= csr_data;
            CSR_TYPE_TWO_K:      type_two_k_ff      <= csr_data;
            CSR_TYPE_TWO_EXTENT: type_two_extent_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Raw displacement j minus i, exact in 33 bits.
   assign raw_d[0] = {req_payload.second_x[31], req_payload.second_x}
                   - {req_payload.first_x[31], req_payload.first_x};
   assign raw_d[1] = {req_payload.second_y[31], req_payload.second_y}
                   - {req_payload.first_y[31], req_payload.first_y};
   assign raw_d[2] = {req_payload.second_z[31], req_payload.second_z}
                   - {req_payload.first_z[31], req_payload.first_z};

   // Minimum image fold of the axis just divided: the remainder of |d| by L is
   // mirrored for negative d, then moved into the half-open range around zero.
   assign wrap_rem = div_rsp.rem[31:0];
   always_comb begin
      if (d_ff[axis_ff][32] && wrap_rem != '0) begin
         wrap_pos = {1'b0, box_length_ff} - {1'b0, wrap_rem};
      end else begin
         wrap_pos = {1'b0, wrap_rem};
      end
      if ({wrap_pos, 1'b0} > {2'b0, box_length_ff}) begin
         wrap_fin = wrap_pos - {1'b0, box_length_ff};
      end else begin
         wrap_fin = wrap_pos;
      end
   end

   // -log2 of the fraction: integer part from the normalizing shift, minus the
   // fraction bits found by repeated squaring.
   assign nl2   = {shift_ff, 32'b0} - {6'b0, lm_ff};
   assign log_t = mul_p[63:31];
   assign prod_wide = {40'b0, mul_p};

   assign energy = over_ff ? ENERGY_MAX :
                   (acc_ff[103:81] != '0) ? ENERGY_MAX : acc_ff[80:33];
   assign sum_wide = {1'b0, (fop_ff ? 56'b0 : sum_ff)} + {9'b0, energy};

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         force_mag[c] = over_ff ? {9'b0, FORCE_MIN_MAG} : fmag_ff[c];
      end
   end

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      fop_in       = fop_ff;
      d_in         = d_ff;
      k_in         = k_ff;
      r0_in        = r0_ff;
      r0sq_in      = r0sq_ff;
      acc_in       = acc_ff;
      over_in      = over_ff;
      f_in         = f_ff;
      norm_in      = norm_ff;
      shift_in     = shift_ff;
      m_in         = m_ff;
      lm_in        = lm_ff;
      nl_in        = nl_ff;
      q_in         = q_ff;
      g_in         = g_ff;
      tsat_in      = tsat_ff;
      tlow_in      = tlow_ff;
      fmag_in      = fmag_ff;
      sum_in       = sum_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      div_req      = '0;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               d_in    = raw_d;
               fop_in  = req_payload.first_of_pass;
               over_in = 1'b0;
               axis_in = '0;
               step_in = '0;
               k_in    = spring_k_ff;
               r0_in   = max_extent_ff;
               if (use_type_table_ff) begin
                  if (req_payload.bond_type == 2'd2 && NUM_BOND_TYPES >= 2) begin
                     k_in  = type_two_k_ff;
                     r0_in = type_two_extent_ff;
                  end else begin
                     k_in  = type_one_k_ff;
                     r0_in = type_one_extent_ff;
                  end
               end
               state_in = (box_length_ff != '0) ? ST_WRAP_GO : ST_SQUARE;
            end
         end

         ST_WRAP_GO: begin
            div_req.start = 1'b1;
            div_req.numer = {mag32(d_ff[axis_ff]), 64'b0};
            div_req.denom = {32'b0, box_length_ff};
            div_req.iters = DIV_CNT_W'(32);
            state_in      = ST_WRAP_WAIT;
         end

         ST_WRAP_WAIT: begin
            if (div_rsp.done) begin
               d_in[axis_ff] = signed'(wrap_fin);
               if (axis_ff == 2'd2) begin
                  step_in  = '0;
                  state_in = ST_SQUARE;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = ST_WRAP_GO;
               end
            end
         end

         // r0 squared first, then the three squared components summed.
         ST_SQUARE: begin
            case (step_ff)
               6'd0: begin
                  mul_a = r0_ff;
                  mul_b = r0_ff;
               end
               6'd1: begin
                  mul_a = mag32(d_ff[0]);
                  mul_b = mag32(d_ff[0]);
               end
               6'd2: begin
                  mul_a = mag32(d_ff[1]);
                  mul_b = mag32(d_ff[1]);
               end
               6'd3: begin
                  mul_a = mag32(d_ff[2]);
                  mul_b = mag32(d_ff[2]);
               end
               default: ;
            endcase
            if (step_ff == 6'd0) begin
               acc_in = '0;
            end else if (step_ff == 6'd1) begin
               r0sq_in = mul_p;
            end else begin
               acc_in = acc_ff + prod_wide;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd4) begin
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (acc_ff[103:64] != '0 || acc_ff[63:0] >= r0sq_ff) begin
               over_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_FACT_GO;
            end
         end

         ST_FACT_GO: begin
            div_req.start = 1'b1;
            div_req.numer = {r0sq_ff - acc_ff[63:0], 32'b0};
            div_req.denom = r0sq_ff;
            div_req.iters = DIV_CNT_W'(96);
            state_in      = ST_FACT_WAIT;
         end

         ST_FACT_WAIT: begin
            if (div_rsp.done) begin
               f_in = div_rsp.quot[32:0];
               if (div_rsp.quot[32:0] == '0) begin
                  over_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  norm_in  = div_rsp.quot[32:0];
                  shift_in = '0;
                  state_in = ST_NORM;
               end
            end
         end

         ST_NORM: begin
            if (norm_ff[32]) begin
               m_in     = norm_ff[32:1];
               lm_in    = '0;
               step_in  = '0;
               state_in = ST_LOG;
            end else begin
               norm_in  = {norm_ff[31:0], 1'b0};
               shift_in = shift_ff + 1'b1;
            end
         end

         // Even steps square the mantissa, odd steps take the product and
         // record one fraction bit of log2, most significant first.
         ST_LOG: begin
            mul_a = m_ff;
            mul_b = m_ff;
            if (step_ff[0]) begin
               if (log_t[32]) begin
                  m_in = log_t[32:1];
                  lm_in[5'd31 - step_ff[5:1]] = 1'b1;
               end else begin
                  m_in = log_t[31:0];
               end
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd63) begin
               step_in  = '0;
               state_in = ST_LN;
            end
         end

         // Scale log2 by ln 2.
         ST_LN: begin
            mul_b = LN2_Q32;
            if (step_ff == 6'd0) begin
               mul_a = nl2[31:0];
            end else begin
               mul_a = {26'b0, nl2[37:32]};
            end
            if (step_ff == 6'd1) begin
               acc_in = {72'b0, mul_p[63:32]};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd2) begin
               nl_in    = acc_ff[37:0] + mul_p[37:0];
               step_in  = '0;
               state_in = ST_KNL;
            end
         end

         // q = (k * nl) >> 32 from two partial products.
         ST_KNL: begin
            mul_a = k_ff;
            if (step_ff == 6'd0) begin
               mul_b = nl_ff[31:0];
            end else begin
               mul_b = {26'b0, nl_ff[37:32]};
            end
            if (step_ff == 6'd1) begin
               acc_in = {72'b0, mul_p[63:32]};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd2) begin
               q_in     = acc_ff[38:0] + mul_p[38:0];
               step_in  = '0;
               state_in = ST_QR;
            end
         end

         // q * r0^2 from four partial products into the wide accumulator.
         ST_QR: begin
            case (step_ff)
               6'd0: begin
                  mul_a = q_ff[31:0];
                  mul_b = r0sq_ff[31:0];
               end
               6'd1: begin
                  mul_a = q_ff[31:0];
                  mul_b = r0sq_ff[63:32];
               end
               6'd2: begin
                  mul_a = {25'b0, q_ff[38:32]};
                  mul_b = r0sq_ff[31:0];
               end
               6'd3: begin
                  mul_a = {25'b0, q_ff[38:32]};
                  mul_b = r0sq_ff[63:32];
               end
               default: ;
            endcase
            case (step_ff)
               6'd0: acc_in = '0;
               6'd1: acc_in = acc_ff + prod_wide;
               6'd2: acc_in = acc_ff + (prod_wide << 32);
               6'd3: acc_in = acc_ff + (prod_wide << 32);
               6'd4: acc_in = acc_ff + (prod_wide << 64);
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd4) begin
               state_in = ST_G_GO;
            end
         end

         ST_G_GO: begin
            div_req.start = 1'b1;
            div_req.numer = {k_ff, 64'b0};
            div_req.denom = {31'b0, f_ff};
            div_req.iters = DIV_CNT_W'(64);
            state_in      = ST_G_WAIT;
         end

         ST_G_WAIT: begin
            if (div_rsp.done) begin
               g_in     = div_rsp.quot;
               step_in  = '0;
               state_in = ST_FORCE;
            end
         end

         // Per axis: high half of g times |d| for the range test, then the low
         // half for the fraction.
         ST_FORCE: begin
            case (step_ff)
               6'd0: begin
                  mul_a = g_ff[63:32];
                  mul_b = mag32(d_ff[0]);
               end
               6'd1: begin
                  mul_a = g_ff[31:0];
                  mul_b = mag32(d_ff[0]);
               end
               6'd2: begin
                  mul_a = g_ff[63:32];
                  mul_b = mag32(d_ff[1]);
               end
               6'd3: begin
                  mul_a = g_ff[31:0];
                  mul_b = mag32(d_ff[1]);
               end
               6'd4: begin
                  mul_a = g_ff[63:32];
                  mul_b = mag32(d_ff[2]);
               end
               6'd5: begin
                  mul_a = g_ff[31:0];
                  mul_b = mag32(d_ff[2]);
               end
               default: ;
            endcase
            case (step_ff)
               6'd1, 6'd3, 6'd5: begin
                  tsat_in = mul_p >= 64'h80_0000;
                  tlow_in = mul_p[22:0];
               end
               6'd2: fmag_in[0] = tsat_ff ? {9'b0, FORCE_MIN_MAG} :
                                  {10'b0, tlow_ff, 16'b0} + {1'b0, mul_p[63:16]};
               6'd4: fmag_in[1] = tsat_ff ? {9'b0, FORCE_MIN_MAG} :
                                  {10'b0, tlow_ff, 16'b0} + {1'b0, mul_p[63:16]};
               6'd6: fmag_in[2] = tsat_ff ? {9'b0, FORCE_MIN_MAG} :
                                  {10'b0, tlow_ff, 16'b0} + {1'b0, mul_p[63:16]};
               default: ;
            endcase
            step_in = step_ff + 1'b1;
            if (step_ff == 6'd6) begin
               state_in = ST_FINISH;
            end
         end

         // Wait for the output register, then publish and add to the pass sum.
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               sum_in                 = sum_wide[56] ? SUM_MAX : sum_wide[55:0];
               rsp_in.force_x         = force_value(d_ff[0], force_mag[0]);
               rsp_in.force_y         = force_value(d_ff[1], force_mag[1]);
               rsp_in.force_z         = force_value(d_ff[2], force_mag[2]);
               rsp_in.bond_energy     = energy;
               rsp_in.energy_total    = sum_wide[56] ? SUM_MAX : sum_wide[55:0];
               rsp_in.overstretched   = over_ff;
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
      rsp_ff <= rsp_in;
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      axis_ff  <= axis_in;
      fop_ff   <= fop_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      r0_ff    <= r0_in;
      r0sq_ff  <= r0sq_in;
      acc_ff   <= acc_in;
      over_ff  <= over_in;
      f_ff     <= f_in;
      norm_ff  <= norm_in;
      shift_ff <= shift_in;
      m_ff     <= m_in;
      lm_ff    <= lm_in;
      nl_ff    <= nl_in;
      q_ff     <= q_in;
      g_ff     <= g_in;
      tsat_ff  <= tsat_in;
      tlow_ff  <= tlow_in;
      fmag_ff  <= fmag_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A new result appears only out of the finishing step.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finishing step");

   // An overstretched bond reports saturated energy.
   a_over_energy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overstretched) |-> (rsp_ff.bond_energy == ENERGY_MAX))
      else $error("overstretched bond without saturated energy");

   // The pass sum can never be smaller than the bond just added.
   a_total_covers_bond: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.energy_total >= {8'b0, rsp_ff.bond_energy}))
      else $error("pass energy below bond energy");

   // The divider is started only from a launch state.
   a_div_launch: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (state_ff == ST_WRAP_GO || state_ff == ST_FACT_GO
                         || state_ff == ST_G_GO))
      else $error("divider started outside a launch state");

endmodule

### bench/fene_bond_force_tb.sv
// Self-checking bench for the FENE bond force unit (fene_bond_force).
// Predicts force, bond energy, pass energy and overstretch per bond, checks each
// result transaction. Depends on fbf_pkg and the RTL of fene_bond_force.
module fene_bond_force_tb import fbf_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TYPES    = 2;
   localparam int STALL_LIMIT  = 5000;   // cycles without any transaction
   localparam int SETTLE_TIME  = 600;    // worst-case bond latency with margin

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   fbf_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   fbf_rsp_type rsp_payload;
   logic        csr_write = 1'b0;
   logic [2:0]  csr_index = CSR_SPRING_K;
   logic [31:0] csr_data = '0;

   fene_bond_force #(.NUM_BOND_TYPES(NUM_TYPES)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Shadow copy of the configuration registers and of the pass energy.
   bit [31:0] spring_k_q, extent_q, box_q;
   bit [31:0] one_k_q, one_extent_q, two_k_q, two_extent_q;
   bit        table_on_q;
   bit [55:0] pass_energy_q;

   fbf_rsp_type pending_rsp[$];
   int  error_count = 0;
   bit  sender_idles = 1'b1;
   bit  receiver_idles = 1'b1;
   int  stall_left = 0;
   int  quiet_cycles = 0;

   // Minimum-image fold of one displacement component into the periodic box.
   function automatic longint fold_axis(longint d);
      longint len, r;
      if (box_q == 0) return d;
      len = longint'({32'b0, box_q});
      r = d % len;
      if (r < 0) r += len;
      if (2 * r > len) r -= len;
      return r;
   endfunction

   // -ln(f / 2^32) in Q.32, log2 found by repeated squaring of the mantissa.
   function automatic bit [63:0] neg_log_q32(bit [63:0] f);
      int        p;
      bit [63:0] m, lm, nl2, hi, lo;
      p = 32;
      while (p > 0 && f[p] == 1'b0) p--;
      m = (p == 32) ? (f >> 1) : (f << (31 - p));
      lm = 0;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= 64'h1_0000_0000) begin
            m = m >> 1;
            lm[i] = 1'b1;
         end
      end
      nl2 = (64'(32 - p) << 32) - lm;
      hi = nl2 >> 32;
      lo = nl2 & 64'hFFFF_FFFF;
      return hi * 64'(LN2_Q32) + ((lo * 64'(LN2_Q32)) >> 32);
   endfunction

   // One force component: sign of d times (g * |d|) >> 16, saturated to 40 bits.
   function automatic bit [39:0] force_axis(bit [63:0] g, longint d, bit over);
      bit [63:0] a, mag, t;
      if (d == 0) return '0;
      a = (d < 0) ? 64'(-d) : 64'(d);
      if (over) begin
         mag = 64'(FORCE_MIN_MAG);
      end else begin
         t = (g >> 32) * a;
         if (t >= 64'(1) << 23) mag = 64'(FORCE_MIN_MAG);
         else mag = (t << 16) + (((g & 64'hFFFF_FFFF) * a) >> 16);
      end
      if (d > 0) return (mag > 64'(FORCE_MAX)) ? FORCE_MAX : mag[39:0];
      if (mag > 64'(FORCE_MIN_MAG)) mag = 64'(FORCE_MIN_MAG);
      return 40'(64'(0) - mag);
   endfunction

   // Works out the result of one bond and advances the pass energy.
   function automatic fbf_rsp_type predict_bond(fbf_req_type b);
      longint      d[3];
      bit [63:0]   k, r0, a, sq, rsq, r0sq, num, f, g, energy, nl, q;
      bit [64:0]   acc;
      bit [127:0]  prod;
      bit          over;
      fbf_rsp_type r;
      d[0] = fold_axis(longint'(b.second_x) - longint'(b.first_x));
      d[1] = fold_axis(longint'(b.second_y) - longint'(b.first_y));
      d[2] = fold_axis(longint'(b.second_z) - longint'(b.first_z));
      k = spring_k_q;
      r0 = extent_q;
      if (table_on_q) begin
         if (b.bond_type == 2'd2 && NUM_TYPES >= 2) begin
            k = two_k_q;
            r0 = two_extent_q;
         end else begin
            k = one_k_q;
            r0 = one_extent_q;
         end
      end
      over = 1'b0;
      rsq = 0;
      for (int i = 0; i < 3; i++) begin
         a = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
         sq = a * a;
         acc = 65'(rsq) + 65'(sq);
         if (acc[64]) over = 1'b1;
         rsq = acc[63:0];
      end
      r0sq = r0 * r0;
      if (rsq >= r0sq) over = 1'b1;
      f = 0;
      g = 0;
      if (!over) begin
         num = r0sq - rsq;
         prod = (128'(num) << 32) / 128'(r0sq);
         f = prod[63:0];
         if (f == 0) over = 1'b1;
      end
      if (over) begin
         energy = 64'(ENERGY_MAX);
      end else begin
         g = (k << 32) / f;
         nl = neg_log_q32(f);
         prod = 128'(k) * 128'(nl);
         q = prod[95:32];
         prod = 128'(q) * 128'(r0sq);
         if (prod[127:81] != 0) energy = 64'(ENERGY_MAX);
         else energy = 64'(prod[80:33]);
      end
      if (b.first_of_pass) pass_energy_q = '0;
      acc = 65'(pass_energy_q) + 65'(energy);
      pass_energy_q = (acc > 65'(SUM_MAX)) ? SUM_MAX : acc[55:0];
      r.force_x = force_axis(g, d[0], over);
      r.force_y = force_axis(g, d[1], over);
      r.force_z = force_axis(g, d[2], over);
      r.bond_energy = energy[47:0];
      r.energy_total = pass_energy_q;
      r.overstretched = over;
      return r;
   endfunction

   // Result checker: every accepted result is matched against the oldest
   // prediction, field by field.
   always @(posedge clock) begin
      fbf_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: result with nothing expected: %p", $time, rsp_payload);
            error_count++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_payload.force_x !== want.force_x) begin
               $display("%0t: force_x expected %h actual %h", $time, want.force_x,
                        rsp_payload.force_x);
               error_count++;
            end
            if (rsp_payload.force_y !== want.force_y) begin
               $display("%0t: force_y expected %h actual %h", $time, want.force_y,
                        rsp_payload.force_y);
               error_count++;
            end
            if (rsp_payload.force_z !== want.force_z) begin
               $display("%0t: force_z expected %h actual %h", $time, want.force_z,
                        rsp_payload.force_z);
               error_count++;
            end
            if (rsp_payload.bond_energy !== want.bond_energy) begin
               $display("%0t: bond_energy expected %h actual %h", $time,
                        want.bond_energy, rsp_payload.bond_energy);
               error_count++;
            end
            if (rsp_payload.energy_total !== want.energy_total) begin
               $display("%0t: energy_total expected %h actual %h", $time,
                        want.energy_total, rsp_payload.energy_total);
               error_count++;
            end
            if (rsp_payload.overstretched !== want.overstretched) begin
               $display("%0t: overstretched expected %b actual %b", $time,
                        want.overstretched, rsp_payload.overstretched);
               error_count++;
            end
         end
      end
   end

   // The receiver stalls in random bursts while enabled.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else if (receiver_idles && $urandom_range(0, 2) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(0, 20);
      end
   end

   // Watchdog: too long without any transaction on either channel ends the run.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("fene_bond_force test failed");
            $finish;
         end
      end
   end

   // Sends one bond transaction, with an optional gap in front of it. The
   // prediction is taken at the accepting edge.
   task automatic send_bond(fbf_req_type b);
      if (sender_idles && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= b;
      do @(posedge clock); while (req_stall);
      pending_rsp.push_back(predict_bond(b));
   endtask

   // Stops sending and waits until every predicted result has been checked.
   task automatic drain;
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Register write; only called while the block is idle.
   task automatic csr_poke(logic [2:0] idx, bit [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_SPRING_K:        spring_k_q = val;
         CSR_MAX_EXTENT:      extent_q = val;
         CSR_USE_TYPE_TABLE:  table_on_q = val[0];
         CSR_BOX_LENGTH:      box_q = val;
         CSR_TYPE_ONE_K:      one_k_q = val;
         CSR_TYPE_ONE_EXTENT: one_extent_q = val;
         CSR_TYPE_TWO_K:      two_k_q = val;
         CSR_TYPE_TWO_EXTENT: two_extent_q = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Picks a first position so that first + d stays inside the signed range.
   function automatic longint place_first(longint d);
      longint lo, hi;
      lo = (d < 0) ? -longint'(2147483648) - d : -longint'(2147483648);
      hi = (d < 0) ? longint'(2147483647) : longint'(2147483647) - d;
      return lo + longint'($urandom_range(0, 32'(hi - lo)));
   endfunction

   function automatic fbf_req_type make_bond(longint dx, longint dy, longint dz,
                                             bit [1:0] btype, bit first);
      fbf_req_type b;
      longint      p;
      p = place_first(dx);
      b.first_x = 32'(p);
      b.second_x = 32'(p + dx);
      p = place_first(dy);
      b.first_y = 32'(p);
      b.second_y = 32'(p + dy);
      p = place_first(dz);
      b.first_z = 32'(p);
      b.second_z = 32'(p + dz);
      b.bond_type = btype;
      b.first_of_pass = first;
      return b;
   endfunction

   function automatic longint signed_upto(longint m);
      longint v;
      v = longint'($urandom_range(0, 32'(m)));
      return ($urandom_range(0, 1) != 0) ? -v : v;
   endfunction

   function automatic bit [31:0] extent_for(bit [1:0] btype);
      if (!table_on_q) return extent_q;
      return (btype == 2'd2) ? two_extent_q : one_extent_q;
   endfunction

   // Random bond: mostly well inside the extent, some at its edge, some with
   // positions drawn over the whole field range and some very short ones.
   task automatic send_random_bond;
      fbf_req_type b;
      bit [1:0]    btype;
      bit          first;
      longint      r0, edge_d;
      int          roll;
      btype = 2'($urandom_range(0, 3));
      first = ($urandom_range(0, 15) == 0);
      r0 = longint'(extent_for(btype));
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         b = make_bond(signed_upto(r0 / 2), signed_upto(r0 / 2), signed_upto(r0 / 2),
                       btype, first);
      end else if (roll < 82) begin
         edge_d = r0 - 2 + longint'($urandom_range(0, 4));
         if (edge_d > longint'(32'hFFFF_FFFF)) edge_d = longint'(32'hFFFF_FFFF);
         if (edge_d < 0) edge_d = 0;
         b = make_bond(($urandom_range(0, 1) != 0) ? -edge_d : edge_d,
                       signed_upto(r0 / 64), 0, btype, first);
      end else if (roll < 94) begin
         b = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, btype, first};
      end else begin
         b = make_bond(signed_upto(8), signed_upto(8), signed_upto(8), btype, first);
      end
      send_bond(b);
   endtask

   // Default registers: zero length, unit length, the edge of the extent,
   // the widest positions, every bond type and a pass restart.
   task automatic test_default_registers;
      send_bond(make_bond(0, 0, 0, 2'd0, 1'b1));
      send_bond(make_bond(65536, 0, 0, 2'd1, 1'b0));
      send_bond(make_bond(-65536, 32768, -16384, 2'd3, 1'b0));
      send_bond(make_bond(98303, 0, 0, 2'd2, 1'b0));
      send_bond(make_bond(98304, 0, 0, 2'd0, 1'b0));
      send_bond(make_bond(0, -98304, 0, 2'd1, 1'b0));
      send_bond({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, 2'd3, 1'b0});
      send_bond({{3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, 2'd2, 1'b0});
      send_bond({{6{32'h8000_0000}}, 2'd0, 1'b1});
      send_bond(make_bond(1, -1, 0, 2'd1, 1'b0));
      drain;
   endtask

   // Per-type table: every type code, one bond stretched to type one's extent.
   task automatic test_type_table;
      csr_poke(CSR_TYPE_ONE_K, 32'h0002_0000);
      csr_poke(CSR_TYPE_ONE_EXTENT, 32'h0001_0000);
      csr_poke(CSR_TYPE_TWO_K, 32'h0000_8000);
      csr_poke(CSR_TYPE_TWO_EXTENT, 32'h0003_0000);
      csr_poke(CSR_USE_TYPE_TABLE, 32'd1);
      for (int t = 0; t < 4; t++) send_bond(make_bond(32768, -16384, 0, 2'(t), 1'b0));
      send_bond(make_bond(65536, 0, 0, 2'd1, 1'b0));
      send_bond(make_bond(65536, 65536, 0, 2'd2, 1'b0));
      drain;
      csr_poke(CSR_USE_TYPE_TABLE, 32'd0);
   endtask

   // Box wrap: exactly half a box stays positive, just past it folds back,
   // multiples of the box fold to small values; tiny and huge boxes too.
   task automatic test_box_wrap;
      csr_poke(CSR_BOX_LENGTH, 32'h0004_0000);
      send_bond(make_bond(32'h0002_0000, 0, 0, 2'd0, 1'b1));
      send_bond(make_bond(32'h0002_0001, 0, 0, 2'd0, 1'b0));
      send_bond(make_bond(-32'sh0002_0000, 0, 0, 2'd0, 1'b0));
      send_bond(make_bond(3 * 32'h0004_0000 + 100, -5 * 32'h0004_0000 - 7, 0, 2'd1, 1'b0));
      send_bond({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'd0, 1'b0});
      drain;
      csr_poke(CSR_BOX_LENGTH, 32'd1);
      send_bond({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 2'd0, 1'b0});
      drain;
      csr_poke(CSR_BOX_LENGTH, 32'hFFFF_FFFF);
      send_bond({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, 2'd0, 1'b0});
      send_bond(make_bond(65536, 0, 0, 2'd0, 1'b0));
      drain;
      csr_poke(CSR_BOX_LENGTH, 32'd0);
   endtask

   // Extreme constants, and a bond so close to the largest extent that the
   // fraction truncates to zero.
   task automatic test_extreme_constants;
      longint m, c, deficit;
      csr_poke(CSR_SPRING_K, 32'd0);
      send_bond(make_bond(65536, 0, 0, 2'd0, 1'b0));
      drain;
      csr_poke(CSR_SPRING_K, 32'hFFFF_FFFF);
      send_bond(make_bond(65536, 0, 0, 2'd0, 1'b0));
      send_bond(make_bond(0, 0, 0, 2'd0, 1'b0));
      drain;
      csr_poke(CSR_MAX_EXTENT, 32'd1);
      send_bond(make_bond(0, 0, 0, 2'd0, 1'b1));
      send_bond(make_bond(1, 0, 0, 2'd0, 1'b0));
      drain;
      csr_poke(CSR_SPRING_K, 32'h0001_0000);
      csr_poke(CSR_MAX_EXTENT, 32'hFFFF_FFFF);
      m = 858993459;
      deficit = 8 * m - 1;
      c = longint'($sqrt(real'(deficit)));
      while (c * c > deficit) c--;
      send_bond(make_bond(3 * m, 4 * m - 1, c, 2'd0, 1'b0));
      send_bond(make_bond(3 * m, 4 * m - 1, 0, 2'd0, 1'b0));
      send_bond(make_bond(3 * m, 4 * m, 0, 2'd0, 1'b0));
      drain;
      csr_poke(CSR_SPRING_K, RESET_SPRING_K);
      csr_poke(CSR_MAX_EXTENT, RESET_MAX_EXTENT);
   endtask

   // The sender holds off until the block has delivered everything.
   task automatic test_hold_off;
      repeat (6) send_random_bond();
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (6) send_random_bond();
      drain;
   endtask

   function automatic bit [31:0] random_constant(bit extent);
      case ($urandom_range(0, 9))
         0: return extent ? 32'd1 : 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return extent ? $urandom_range(32'h0000_1000, 32'h0040_0000)
                                : $urandom_range(0, 32'h0010_0000);
      endcase
   endfunction

   // Random phases, each with fresh registers; the last runs without idling.
   task automatic test_random_phases(int phases, int per_phase);
      longint box;
      for (int p = 0; p < phases; p++) begin
         if (p == phases - 1) begin
            sender_idles = 1'b0;
            receiver_idles = 1'b0;
         end
         csr_poke(CSR_SPRING_K, random_constant(1'b0));
         csr_poke(CSR_MAX_EXTENT, random_constant(1'b1));
         csr_poke(CSR_TYPE_ONE_K, random_constant(1'b0));
         csr_poke(CSR_TYPE_ONE_EXTENT, random_constant(1'b1));
         csr_poke(CSR_TYPE_TWO_K, random_constant(1'b0));
         csr_poke(CSR_TYPE_TWO_EXTENT, random_constant(1'b1));
         csr_poke(CSR_USE_TYPE_TABLE, $urandom_range(0, 1));
         case ($urandom_range(0, 3))
            0, 1: box = 0;
            2: box = longint'(extent_q) * longint'($urandom_range(1, 3))
                     + longint'($urandom_range(0, 255));
            default: box = longint'($urandom);
         endcase
         if (box > longint'(32'hFFFF_FFFF)) box = longint'(32'hFFFF_FFFF);
         csr_poke(CSR_BOX_LENGTH, 32'(box));
         repeat (per_phase) send_random_bond();
         drain;
      end
   endtask

   initial begin
      spring_k_q = RESET_SPRING_K;
      extent_q = RESET_MAX_EXTENT;
      table_on_q = 1'b0;
      box_q = 0;
      one_k_q = RESET_SPRING_K;
      one_extent_q = RESET_MAX_EXTENT;
      two_k_q = RESET_SPRING_K;
      two_extent_q = RESET_MAX_EXTENT;
      pass_energy_q = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_registers();
      test_type_table();
      test_box_wrap();
      test_extreme_constants();
      test_hold_off();
      test_random_phases(14, 118);
      drain;
      repeat (SETTLE_TIME) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("fene_bond_force test passed");
      end else begin
         $display("fene_bond_force test failed");
      end
      $finish;
   end
endmodule
